>>> hw/rtl/pic_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the priority interrupt controller
// no dependencies; used by the channel interfaces and every module

package pic_pkg;

   localparam int unsigned LEVELS = 8;

   // transaction modes
   typedef enum logic [2:0] {
      MODE_TICK       = 3'd0,
      MODE_RAISE      = 3'd1,
      MODE_FINISH     = 3'd2,
      MODE_WRITE_CMD  = 3'd3,
      MODE_WRITE_DATA = 3'd4,
      MODE_WRITE_MASK = 3'd5
   } mode_type;

   // pending command codes
   typedef enum logic [2:0] {
      CMD_IDLE       = 3'd0,
      CMD_READ_REQ   = 3'd1,
      CMD_READ_SRV   = 3'd2,
      CMD_READ_MASK  = 3'd3,
      CMD_WRITE_MASK = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  irq_line;
      logic [15:0] bus_value;
      logic        cpu_busy_flag;
      logic [2:0]  cpu_level;
   } pic_req_type;

   typedef struct packed {
      logic        fire;
      logic [7:0]  vector;
      logic [2:0]  level;
      logic [15:0] data_word;
      logic [7:0]  request_bits;
      logic [7:0]  service_bits;
      logic [7:0]  mask_bits;
   } pic_rsp_type;

endpackage

>>> hw/rtl/pic_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake carrying one controller transaction
// depends on pic_pkg for the payload type

interface pic_req_if import pic_pkg::*; ();
   logic        valid;
   logic        ready;
   pic_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pic_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready handshake carrying one register report
// depends on pic_pkg for the payload type

interface pic_rsp_if import pic_pkg::*; ();
   logic        valid;
   logic        ready;
   pic_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pic_core.sv
`timescale 1ns / 1ps
// controller state and its registered update for one accepted transaction
// depends on pic_pkg; instantiated by priority_interrupt_controller

module pic_core import pic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  pic_req_type item,
   input  logic [7:0]  vector_base,
   output pic_rsp_type result
);

   logic [7:0]  request_ff, request_in;
   logic [7:0]  service_ff, service_in;
   logic [7:0]  mask_ff, mask_in;
   logic [15:0] data_ff, data_in;
   cmd_type     cmd_ff, cmd_in;

   logic [7:0]  eligible;
   logic [2:0]  top_level;
   logic        found;
   logic        fire;

   // requests above the cpu priority, highest one wins
   always_comb begin
      found     = 1'b0;
      top_level = 3'd0;
      for (int i = 0; i < LEVELS; i++) begin
         eligible[i] = request_ff[i] && (3'(i) > item.cpu_level);
         if (eligible[i]) begin
            found     = 1'b1;
            top_level = 3'(i);
         end
      end
   end

   // next state for the transaction
   always_comb begin
      request_in = request_ff;
      service_in = service_ff;
      mask_in    = mask_ff;
      data_in    = data_ff;
      cmd_in     = cmd_ff;
      fire       = 1'b0;
      case (mode_type'(item.mode))
         MODE_TICK: begin
            if (!item.cpu_busy_flag && found) begin
               fire       = 1'b1;
               request_in = request_ff & ~(8'b1 << top_level);
               service_in = service_ff | (8'b1 << top_level);
            end
            // pending command sees the register values after the fire
            case (cmd_ff)
               CMD_READ_REQ:   data_in = {8'b0, request_in};
               CMD_READ_SRV:   data_in = {8'b0, service_in};
               CMD_READ_MASK:  data_in = {8'b0, mask_ff};
               CMD_WRITE_MASK: mask_in = data_ff[7:0];
               default: begin
               end
            endcase
            cmd_in = CMD_IDLE;
         end
         MODE_RAISE: begin
            if (!service_ff[item.irq_line] && !mask_ff[item.irq_line]) begin
               request_in = request_ff | (8'b1 << item.irq_line);
            end
         end
         MODE_FINISH: begin
            service_in = service_ff & ~(8'b1 << item.irq_line);
         end
         MODE_WRITE_CMD: begin
            if (item.bus_value <= 16'(CMD_WRITE_MASK)) begin
               cmd_in = cmd_type'(item.bus_value[2:0]);
            end else begin
               cmd_in = CMD_IDLE;
            end
         end
         MODE_WRITE_DATA: begin
            data_in = item.bus_value;
         end
         MODE_WRITE_MASK: begin
            mask_in = item.bus_value[7:0];
         end
         default: begin
         end
      endcase
   end

   // report of the registers after the transaction
   always_comb begin
      result.fire         = fire;
      result.vector       = fire ? (vector_base | {5'b0, top_level}) : 8'd0;
      result.level        = fire ? top_level : 3'd0;
      result.data_word    = data_in;
      result.request_bits = request_in;
      result.service_bits = service_in;
      result.mask_bits    = mask_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         request_ff <= 8'd0;
         service_ff <= 8'd0;
         mask_ff    <= 8'd0;
         data_ff    <= 16'd0;
         cmd_ff     <= CMD_IDLE;
      end else if (item_valid) begin
         request_ff <= request_in;
         service_ff <= service_in;
         mask_ff    <= mask_in;
         data_ff    <= data_in;
         cmd_ff     <= cmd_in;
      end
   end

   // a fired level is in service afterwards and no longer requested
   a_fire_moves_level: assert property (@(posedge clock) disable iff (reset)
      (item_valid && fire) |=>
         (service_ff[$past(top_level)] && !request_ff[$past(top_level)]))
      else $error("fired level not moved to in-service");

   // only an unblocked tick fires
   a_fire_on_tick: assert property (@(posedge clock) disable iff (reset)
      fire |-> (item.mode == MODE_TICK && !item.cpu_busy_flag))
      else $error("fire outside an unblocked tick");

   // a tick always consumes the pending command
   a_tick_clears_cmd: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.mode == MODE_TICK) |=> (cmd_ff == CMD_IDLE))
      else $error("pending command survived a tick");

   // state holds when no transaction is taken
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !item_valid |=> ($stable(request_ff) && $stable(service_ff) &&
                       $stable(mask_ff) && $stable(data_ff)))
      else $error("state changed without a transaction");

endmodule

>>> hw/rtl/pic_out_buf.sv
`timescale 1ns / 1ps
// two-entry output buffer: result register plus skid register
// depends on pic_pkg; instantiated by priority_interrupt_controller

module pic_out_buf import pic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  pic_rsp_type push_data,
   output logic        space,
   output logic        out_valid,
   input  logic        out_ready,
   output pic_rsp_type out_data
);

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   pic_rsp_type out_data_ff, out_data_in;
   pic_rsp_type skid_data_ff, skid_data_in;

   // room for a new transaction whenever the skid slot is free
   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // refill the result register from skid first, then from the core
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload flops
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid entry only exists behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without a result waiting");

   // a push is never offered while the skid slot is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("push into a full output buffer");

   // a stalled skid entry moves to the result register once it drains
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not forwarded");

endmodule

>>> hw/rtl/priority_interrupt_controller.sv
`timescale 1ns / 1ps
// top level of the eight-level priority interrupt controller
// depends on pic_pkg, pic_req_if, pic_rsp_if, pic_core and pic_out_buf

// The controller takes one transaction per clock while the output buffer has
// room and answers each with one response. Every transaction (tick, raise,
// finish, command, data or mask write) is applied to the request, in-service,
// mask, command and data registers in the cycle it is accepted, so the
// throughput is set by that register update: one transaction per clock while
// the buffer has room. Responses leave through a two-entry buffer, so one
// response may wait on a stalled sink while the next transaction is still
// taken; req ready drops only when both entries are full. The vector base is
// written through csr_wr_en/csr_wr_data and should only change while idle.

module priority_interrupt_controller import pic_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   pic_req_if.sink          req_chan,
   pic_rsp_if.source        rsp_chan
);

   logic        vector_base_ff;
   logic [7:0]  vector_base_q_ff;
   logic        accept;
   logic        space;
   pic_rsp_type core_result;

   // vector base register
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_base_q_ff <= 8'd0;
      end else if (csr_wr_en) begin
         vector_base_q_ff <= csr_wr_data;
      end
   end

   // tracks that the base has been written at least once since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_base_ff <= 1'b0;
      end else if (csr_wr_en) begin
         vector_base_ff <= 1'b1;
      end
   end

   // transaction accepted whenever the output buffer has room
   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   pic_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (accept),
      .item        (req_chan.payload),
      .vector_base (vector_base_q_ff),
      .result      (core_result)
   );

   pic_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

   // a base left unwritten since reset is still zero
   a_base_reset: assert property (@(posedge clock) disable iff (reset)
      !vector_base_ff |-> (vector_base_q_ff == 8'd0))
      else $error("vector base changed without a write");

   // a fired vector always carries the programmed base bits
   a_vector_base: assert property (@(posedge clock) disable iff (reset)
      core_result.fire |->
         ((core_result.vector & vector_base_q_ff) == vector_base_q_ff))
      else $error("fired vector lost base bits");

   // response valid is up in the cycle after an accepted transaction
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_chan.valid)
      else $error("accepted transaction produced no response");

endmodule
